// File: sv/cabpw_pkg.sv
// shared types, constants and helpers for the clipped alpha-blend pixel writer
package cabpw_pkg;

    // defaults for the top-level parameters
    localparam int FRAME_WORDS_DEF = 262144;
    localparam int QUEUE_DEPTH_DEF = 4;

    // field widths
    localparam int DIM_W     = 10;
    localparam int POS_W     = 12;
    localparam int PIX_W     = 32;
    localparam int CFG_IDX_W = 1;
    // row * width + column, wide enough for the largest store
    localparam int SUM_W     = 2 * DIM_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT = 1'b1;

    // register reset values
    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 10'd500;
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 10'd500;

    // request codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // what the back end has to do with one word
    typedef enum logic [1:0] {
        JOB_CLIP  = 2'd0,
        JOB_READ  = 2'd1,
        JOB_WRITE = 2'd2,
        JOB_BLEND = 2'd3
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [PIX_W-1:0]   color;
    } t_job;

    // byte swap from B,G,R,A to A,R,G,B
    function automatic logic [PIX_W-1:0] bgra_to_argb(input logic [PIX_W-1:0] c);
        return {c[7:0], c[15:8], c[23:16], c[31:24]};
    endfunction

    // exact floor(v / 255) for v up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + 17'(v >> 8) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: sv/cabpw_ram.sv
// generic single-write, single-read ram with registered read data
module cabpw_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cabpw_fifo.sv
// small register queue between the front and back ends
module cabpw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int PTR_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/cabpw_front.sv
// front end: takes requests, clips them, forms the address and classifies the job
module cabpw_front #(
    parameter int FRAME_WORDS = cabpw_pkg::FRAME_WORDS_DEF,
    parameter int ADDR_W      = $clog2(FRAME_WORDS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clearing,
    input  logic [cabpw_pkg::DIM_W-1:0] i_fb_width,
    input  logic [cabpw_pkg::DIM_W-1:0] i_fb_height,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic                        i_req_type,
    input  logic signed [cabpw_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [cabpw_pkg::POS_W-1:0] i_pos_y,
    input  logic [cabpw_pkg::PIX_W-1:0] i_src_color,
    output logic                        o_job_valid,
    output cabpw_pkg::t_job             o_job,
    output logic [ADDR_W-1:0]           o_job_addr,
    input  logic                        i_q_full
);
    import cabpw_pkg::*;

    logic               r_valid, n_valid;
    logic               r_type;
    logic [POS_W-1:0]   r_x;
    logic [POS_W-1:0]   r_y;
    logic [PIX_W-1:0]   r_color;

    logic               accept, move;
    logic               in_x, in_y, in_store, hit;
    logic [2*DIM_W-1:0] prod;
    logic [SUM_W-1:0]   sum;
    logic [PIX_W-1:0]   argb;

    assign move   = r_valid && !i_q_full;
    assign o_full = i_clearing || (r_valid && i_q_full);
    assign accept = i_push && !o_full;

    // holding stage
    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (move) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type  <= i_req_type;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_color <= i_src_color;
        end
    end

    // clipping against the visible window
    assign in_x = !r_x[POS_W-1] &&
                  ({1'b0, r_x[POS_W-2:0]} < POS_W'(i_fb_width));
    assign in_y = !r_y[POS_W-1] &&
                  ({1'b0, r_y[POS_W-2:0]} < POS_W'(i_fb_height));

    // linear address and store bound
    assign prod     = r_y[DIM_W-1:0] * i_fb_width;
    assign sum      = SUM_W'(prod) + SUM_W'(r_x[DIM_W-1:0]);
    assign in_store = (sum < SUM_W'(FRAME_WORDS));
    assign hit      = in_x && in_y && in_store;
    assign argb     = bgra_to_argb(r_color);

    // job classification
    always_comb begin
        o_job.color = argb;
        if (!hit) begin
            o_job.kind = JOB_CLIP;
        end else if (r_type == REQ_READ) begin
            o_job.kind = JOB_READ;
        end else if (argb[31:24] == ALPHA_OPAQUE) begin
            o_job.kind = JOB_WRITE;
        end else begin
            o_job.kind = JOB_BLEND;
        end
    end

    assign o_job_valid = move;
    assign o_job_addr  = sum[ADDR_W-1:0];

endmodule

// File: sv/cabpw_back.sv
// back end: sequences store reads, blending and writes, and holds the result word
module cabpw_back #(
    parameter int ADDR_W = $clog2(cabpw_pkg::FRAME_WORDS_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  cabpw_pkg::t_job             i_q_job,
    input  logic [ADDR_W-1:0]           i_q_addr,
    output logic                        o_q_pop,
    output logic                        o_rd_en,
    output logic [ADDR_W-1:0]           o_rd_addr,
    input  logic [cabpw_pkg::PIX_W-1:0] i_rd_data,
    output logic                        o_wr_en,
    output logic [ADDR_W-1:0]           o_wr_addr,
    output logic [cabpw_pkg::PIX_W-1:0] o_wr_data,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [cabpw_pkg::PIX_W-1:0] o_pixel_value,
    output logic                        o_in_range
);
    import cabpw_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_ISSUE = 5'b00010,
        B_RDAT  = 5'b00100,
        B_MIX   = 5'b01000,
        B_DONE  = 5'b10000
    } t_back_state;

    t_back_state      r_state, n_state;
    t_job             r_job;
    logic [ADDR_W-1:0] r_addr;
    logic [15:0]      r_po [4];
    logic [15:0]      r_pn [4];
    logic [PIX_W-1:0] r_res_value;
    logic             r_res_in;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_in;

    logic             out_free;
    logic [PIX_W-1:0] mix;
    logic [7:0]       alpha;

    assign alpha    = r_job.color[31:24];
    assign out_free = !r_out_valid || i_pop;

    // per-channel blend from the registered products
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mix[8*c +: 8] = div255(r_po[c] + r_pn[c]);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) n_state = B_ISSUE;
            end
            B_ISSUE: begin
                if (r_job.kind == JOB_CLIP || r_job.kind == JOB_WRITE) begin
                    n_state = B_DONE;
                end else begin
                    n_state = B_RDAT;
                end
            end
            B_RDAT: begin
                n_state = (r_job.kind == JOB_BLEND) ? B_MIX : B_DONE;
            end
            B_MIX: begin
                n_state = B_DONE;
            end
            B_DONE: begin
                if (out_free) n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // store access
    assign o_q_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign o_rd_en   = (r_state == B_ISSUE) &&
                       (r_job.kind == JOB_READ || r_job.kind == JOB_BLEND);
    assign o_rd_addr = r_addr;
    assign o_wr_en   = ((r_state == B_ISSUE) && (r_job.kind == JOB_WRITE)) ||
                       (r_state == B_MIX);
    assign o_wr_addr = r_addr;
    assign o_wr_data = (r_state == B_MIX) ? mix : r_job.color;

    // result word register
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == B_DONE && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // job capture, products and result
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job  <= i_q_job;
            r_addr <= i_q_addr;
        end
        if (r_state == B_ISSUE) begin
            r_res_value <= (r_job.kind == JOB_WRITE) ? r_job.color : '0;
            r_res_in    <= (r_job.kind == JOB_WRITE);
        end
        if (r_state == B_RDAT) begin
            r_res_value <= i_rd_data;
            r_res_in    <= 1'b1;
            for (int c = 0; c < 4; c++) begin
                r_po[c] <= 16'(i_rd_data[8*c +: 8]) * 16'(ALPHA_OPAQUE - alpha);
                r_pn[c] <= 16'(r_job.color[8*c +: 8]) * 16'(alpha);
            end
        end
        if (r_state == B_MIX) begin
            r_res_value <= mix;
            r_res_in    <= 1'b1;
        end
        if (r_state == B_DONE && out_free) begin
            r_out_value <= r_res_value;
            r_out_in    <= r_res_in;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_pixel_value = r_out_value;
    assign o_in_range    = r_out_in;

endmodule

// File: sv/clipped_alpha_blend_pixel_writer.sv
// Clipped alpha-blend pixel writer: draw requests are clipped to fb_width x fb_height,
// swizzled from BGRA to ARGB and, when alpha is below 255, blended with the stored word
// before write-back; read requests return the stored word. Every request yields one result
// word. The back-end sequencer serves one request at a time in states idle, issue,
// rdat, mix and done (pop from the queue, store read, product stage, divide and write,
// result hand-off); clips and opaque draws skip rdat and mix, and reads skip mix. The
// front end and a QUEUE_DEPTH-deep queue accept until full while the back end works or
// a result waits. After reset a clearing pass zeroes all FRAME_WORDS store words, with
// full staying high; configuration writes are taken at any time.
module clipped_alpha_blend_pixel_writer #(
    parameter int FRAME_WORDS = cabpw_pkg::FRAME_WORDS_DEF,
    parameter int QUEUE_DEPTH = cabpw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cabpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cabpw_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_req_type,
    input  logic signed [cabpw_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [cabpw_pkg::POS_W-1:0] i_pos_y,
    input  logic [cabpw_pkg::PIX_W-1:0]     i_src_color,
    output logic                            empty,
    input  logic                            pop,
    output logic [cabpw_pkg::PIX_W-1:0]     o_pixel_value,
    output logic                            o_in_range
);
    import cabpw_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_WORDS);
    localparam int Q_W    = $bits(t_job) + ADDR_W;

    logic [DIM_W-1:0]  r_fb_width;
    logic [DIM_W-1:0]  r_fb_height;
    logic              r_clearing, n_clearing;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic              f_valid;
    t_job              f_job;
    logic [ADDR_W-1:0] f_addr;
    logic              q_full, q_empty, q_pop;
    logic [Q_W-1:0]    q_data;
    t_job              q_job;
    logic [ADDR_W-1:0] q_addr;

    logic              b_rd_en, b_wr_en;
    logic [ADDR_W-1:0] b_rd_addr, b_wr_addr;
    logic [PIX_W-1:0]  b_wr_data, rd_data;
    logic              m_we;
    logic [ADDR_W-1:0] m_waddr;
    logic [PIX_W-1:0]  m_wdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= FB_WIDTH_RST;
            r_fb_height <= FB_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass after reset
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(FRAME_WORDS - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // front end
    cabpw_front #(
        .FRAME_WORDS (FRAME_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clearing  (r_clearing),
        .i_fb_width  (r_fb_width),
        .i_fb_height (r_fb_height),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_src_color (i_src_color),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .o_job_addr  (f_addr),
        .i_q_full    (q_full)
    );

    // job queue
    cabpw_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_addr, f_job}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign q_job  = q_data[$bits(t_job)-1:0];
    assign q_addr = q_data[Q_W-1:$bits(t_job)];

    // back end
    cabpw_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_job       (q_job),
        .i_q_addr      (q_addr),
        .o_q_pop       (q_pop),
        .o_rd_en       (b_rd_en),
        .o_rd_addr     (b_rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (b_wr_en),
        .o_wr_addr     (b_wr_addr),
        .o_wr_data     (b_wr_data),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_pixel_value (o_pixel_value),
        .o_in_range    (o_in_range)
    );

    // store write port shared with the clearing pass
    assign m_we    = r_clearing || b_wr_en;
    assign m_waddr = r_clearing ? r_clr_addr : b_wr_addr;
    assign m_wdata = r_clearing ? '0 : b_wr_data;

    // frame store
    cabpw_ram #(
        .WIDTH  (PIX_W),
        .DEPTH  (FRAME_WORDS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (b_rd_en),
        .i_raddr (b_rd_addr),
        .o_rdata (rd_data)
    );

endmodule

// File: sv/cabpw_checker.sv
// port-level checks for the pixel writer, bound to the top level
module cabpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_pixel_value,
    input logic        o_in_range
);

    // reset starts the clearing pass with nothing to deliver
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("no clearing pass or stale result after reset");

    // a clipped result carries a zero word
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_in_range |-> o_pixel_value == 32'd0)
        else $error("clipped result with nonzero word");

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pixel_value) && $stable(o_in_range))
        else $error("result word changed while stalled");

    // no result is present right after reset is released
    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result during clearing pass");

endmodule

bind clipped_alpha_blend_pixel_writer cabpw_checker u_cabpw_checker (.*);

// File: tb/tb.sv
// testbench for the clipped alpha-blend pixel writer: directed and random draws and reads
`timescale 1ns / 1ps

module tb;
    import cabpw_pkg::*;

    localparam int STORE_WORDS    = FRAME_WORDS_DEF;
    // the clearing pass after reset moves nothing while it clears each of the STORE_WORDS words
    localparam int IDLE_LIMIT     = 3 * STORE_WORDS;
    localparam int DRAIN_CYCLES   = 10;
    localparam int HOLDOFF_CYCLES = 150;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             hit;
    } t_pixel_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [DIM_W-1:0]        i_cfg_data;
    logic                    push;
    logic                    full;
    logic                    i_req_type;
    logic signed [POS_W-1:0] i_pos_x;
    logic signed [POS_W-1:0] i_pos_y;
    logic [PIX_W-1:0]        i_src_color;
    logic                    empty;
    logic                    pop;
    logic [PIX_W-1:0]        o_pixel_value;
    logic                    o_in_range;

    // predictor state: frame size and stored words, absent entries read as zero
    logic [DIM_W-1:0]        frame_w = FB_WIDTH_RST;
    logic [DIM_W-1:0]        frame_h = FB_HEIGHT_RST;
    logic [PIX_W-1:0]        frame_mem [int unsigned];

    t_pixel_word             expected_words [$];
    int                      mismatch_count = 0;
    int                      idle_cycles = 0;
    int                      burst_left = 0;
    int                      max_gap = 6;
    int                      holdoff_asked = 0;
    int                      holdoff_done = 0;

    clipped_alpha_blend_pixel_writer #(
        .FRAME_WORDS(FRAME_WORDS_DEF),
        .QUEUE_DEPTH(QUEUE_DEPTH_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_src_color   (i_src_color),
        .empty         (empty),
        .pop           (pop),
        .o_pixel_value (o_pixel_value),
        .o_in_range    (o_in_range)
    );

    always #5 i_clk = ~i_clk;

    // clip, swizzle, blend against the stored word and update the store copy; reads return the stored word
    function automatic t_pixel_word predict_pixel(input logic rt,
                                                  input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y,
                                                  input logic [PIX_W-1:0] c);
        t_pixel_word      r;
        int               col;
        int               row;
        int unsigned      addr;
        int               a;
        int               mix;
        logic [PIX_W-1:0] old_w;
        logic [PIX_W-1:0] argb;
        logic [PIX_W-1:0] blended;
        r   = '0;
        col = x;
        row = y;
        if (col < 0 || row < 0 || col >= int'(frame_w) || row >= int'(frame_h))
            return r;
        addr = row * int'(frame_w) + col;
        // sizes past the legal range can point beyond the store
        if (addr >= STORE_WORDS)
            return r;
        old_w = frame_mem.exists(addr) ? frame_mem[addr] : '0;
        if (rt == REQ_READ) begin
            r.value = old_w;
        end else begin
            argb = {c[7:0], c[15:8], c[23:16], c[31:24]};
            if (argb[31:24] != ALPHA_OPAQUE) begin
                a = int'(argb[31:24]);
                for (int sh = 0; sh < PIX_W; sh += 8) begin
                    mix = (int'(old_w[sh +: 8]) * (255 - a) + int'(argb[sh +: 8]) * a) / 255;
                    blended[sh +: 8] = mix[7:0];
                end
                argb = blended;
            end
            frame_mem[addr] = argb;
            r.value = argb;
        end
        r.hit = 1'b1;
        return r;
    endfunction

    // offer one request in bursts with random gaps, wait for the handshake
    task automatic send_pixel(input logic rt, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y, input logic [PIX_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        i_req_type  <= rt;
        i_pos_x     <= x;
        i_pos_y     <= y;
        i_src_color <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected_words.push_back(predict_pixel(rt, x, y, c));
    endtask

    // random request aimed mostly inside the current frame
    task automatic send_random_pixel();
        logic                    rt;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [PIX_W-1:0]        c;
        int                      sel;
        rt  = ($urandom_range(0, 9) < 3) ? REQ_READ : REQ_DRAW;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            x = (frame_w == 0) ? '0 : POS_W'($urandom_range(0, int'(frame_w) - 1));
            y = (frame_h == 0) ? '0 : POS_W'($urandom_range(0, int'(frame_h) - 1));
        end else if (sel == 7) begin
            // just around the clipping edges
            x = POS_W'(int'(frame_w) - 2 + int'($urandom_range(0, 3)));
            y = POS_W'(int'(frame_h) - 2 + int'($urandom_range(0, 3)));
        end else begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end
        c = $urandom;
        // alpha sits in the low byte before the swizzle
        case ($urandom_range(0, 7))
            0, 1:    c[7:0] = ALPHA_OPAQUE;
            2:       c[7:0] = 8'h00;
            default: ;
        endcase
        send_pixel(rt, x, y, c);
    endtask

    // stop offering until every expected word is back, then let the back end settle
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FB_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_FB_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    // reset frame size: opaque, blended, alpha edge cases, corners and clipping
    task automatic test_reset_frame();
        send_pixel(REQ_DRAW, 0, 0, 32'h112233FF);
        send_pixel(REQ_READ, 0, 0, 32'hFFFFFFFF);
        send_pixel(REQ_DRAW, 0, 0, 32'hAABBCC80);
        send_pixel(REQ_DRAW, 0, 0, 32'h12345600);
        send_pixel(REQ_DRAW, 0, 0, 32'hFFFFFFFE);
        send_pixel(REQ_DRAW, 0, 0, 32'h00000001);
        send_pixel(REQ_READ, 0, 0, 32'h00000000);
        send_pixel(REQ_DRAW, 499, 499, 32'hFFFFFFFF);
        send_pixel(REQ_READ, 499, 499, 32'h5A5A5A5A);
        send_pixel(REQ_DRAW, 499, 0, 32'h00000000);
        send_pixel(REQ_DRAW, 500, 0, 32'h445566FF);
        send_pixel(REQ_DRAW, 0, 500, 32'h445566FF);
        send_pixel(REQ_DRAW, -1, 0, 32'h445566FF);
        send_pixel(REQ_DRAW, 0, -1, 32'h445566FF);
        send_pixel(REQ_DRAW, -2048, -2048, 32'hFFFFFFFF);
        send_pixel(REQ_DRAW, 2047, 2047, 32'hFFFFFFFF);
        send_pixel(REQ_READ, 2047, -2048, 32'hFFFFFFFF);
        send_pixel(REQ_READ, 500, 499, 32'h00000000);
        send_pixel(REQ_READ, 1, 1, 32'hA5A5A5A5);
        send_pixel(REQ_DRAW, 1, 1, 32'h000000FF);
        send_pixel(REQ_READ, 1, 1, 32'h00000000);
    endtask

    // one-pixel frame, zero sizes, oversize frame past the store, largest legal frame
    task automatic test_frame_extremes();
        set_frame_size(10'd1, 10'd1);
        send_pixel(REQ_DRAW, 0, 0, 32'h80402010);
        send_pixel(REQ_DRAW, 0, 0, 32'hFF00FF7F);
        send_pixel(REQ_READ, 0, 0, 32'h0);
        send_pixel(REQ_DRAW, 1, 0, 32'h010203FF);
        send_pixel(REQ_DRAW, 0, 1, 32'h010203FF);
        repeat (8) send_random_pixel();

        set_frame_size(10'd0, 10'd500);
        send_pixel(REQ_DRAW, 0, 0, 32'h010203FF);
        send_pixel(REQ_READ, 0, 0, 32'h0);
        repeat (4) send_random_pixel();
        set_frame_size(10'd500, 10'd0);
        send_pixel(REQ_DRAW, 0, 0, 32'h010203FF);
        repeat (4) send_random_pixel();

        set_frame_size(10'd1023, 10'd1023);
        send_pixel(REQ_DRAW, 0, 256, 32'h11223344);
        send_pixel(REQ_DRAW, 255, 256, 32'hCAFEBAFF);
        send_pixel(REQ_READ, 255, 256, 32'h0);
        send_pixel(REQ_DRAW, 256, 256, 32'hCAFEBAFF);
        send_pixel(REQ_READ, 0, 300, 32'h0);
        send_pixel(REQ_DRAW, 1022, 1022, 32'hFFFFFFFF);
        send_pixel(REQ_DRAW, 1022, 255, 32'h9988773C);
        repeat (8) send_random_pixel();

        set_frame_size(10'd512, 10'd512);
        send_pixel(REQ_DRAW, 511, 511, 32'h13579BFF);
        send_pixel(REQ_DRAW, 511, 511, 32'h2468ACC0);
        send_pixel(REQ_READ, 511, 511, 32'h0);
        send_pixel(REQ_DRAW, 512, 0, 32'h13579BFF);
        repeat (8) send_random_pixel();
    endtask

    // receiver holds off while the sender keeps pushing, so the input stalls
    task automatic test_backpressure();
        set_frame_size(10'd8, 10'd8);
        max_gap = 0;
        holdoff_asked++;
        repeat (40) send_random_pixel();
        max_gap = 6;
        wait_drained();
    endtask

    // random frames, mostly small so that draws land on pixels already written
    task automatic test_random_frames();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 3) begin
                w = DIM_W'($urandom_range(100, 512));
                h = DIM_W'($urandom_range(100, 512));
            end else begin
                w = DIM_W'($urandom_range(1, 24));
                h = DIM_W'($urandom_range(1, 24));
            end
            set_frame_size(w, h);
            repeat (80) send_random_pixel();
        end
    endtask

    // receiver: random pop rate that changes every stretch, plus requested hold-offs
    initial begin
        int pct;
        int span;
        pct  = 100;
        span = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_done != holdoff_asked) begin
                pop <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_done++;
            end else begin
                if (span == 0) begin
                    case ($urandom_range(0, 3))
                        0:       pct = 100;
                        1:       pct = 85;
                        2:       pct = 50;
                        default: pct = 15;
                    endcase
                    span = $urandom_range(8, 60);
                end
                span--;
                pop <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    // result check against the oldest expected word, plus the stall watchdog
    always @(posedge i_clk) begin : watch_words
        t_pixel_word want;
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected word, expected none, got pixel %h in_range %b",
                             $time, o_pixel_value, o_in_range);
                end else begin
                    want = expected_words.pop_front();
                    if (o_pixel_value !== want.value || o_in_range !== want.hit) begin
                        mismatch_count++;
                        $display({"%0t: word mismatch, expected pixel %h in_range %b, ",
                                  "got pixel %h in_range %b"},
                                 $time, want.value, want.hit, o_pixel_value, o_in_range);
                    end
                end
            end
        end
    end

    // reset, run the tests in turn, drain and report
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FB_WIDTH;
        i_cfg_data  <= '0;
        push        <= 1'b0;
        i_req_type  <= REQ_DRAW;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_src_color <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame();
        test_frame_extremes();
        test_backpressure();
        test_random_frames();
        wait_drained();

        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: clipped_alpha_blend_pixel_writer.f
sv/cabpw_pkg.sv
sv/cabpw_ram.sv
sv/cabpw_fifo.sv
sv/cabpw_front.sv
sv/cabpw_back.sv
sv/clipped_alpha_blend_pixel_writer.sv
sv/cabpw_checker.sv
tb/tb.sv
